// ----- hw/rtl/scat_pkg.sv -----
package scat_pkg;

    // Fixed field widths of the request and result.
    localparam int ADDR_W    = 32;
    localparam int MODE_W    = 2;
    localparam int OUTC_W    = 2;
    localparam int WAYOUT_W  = 2;
    localparam int SHIFT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int LFSR_W    = 8;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ACCESS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INV_ALL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INV_LINE = 2'd2;

    // Result outcomes.
    localparam logic [OUTC_W-1:0] OUT_HIT      = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_MISS     = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_BYPASS   = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_INV_DONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [OUTC_W-1:0]   outcome;
        logic [WAYOUT_W-1:0] hit_way;
        logic [ADDR_W-1:0]   memory_address;
    } t_rsp;

    typedef struct packed {
        logic               cache_enable;
        logic [SHIFT_W-1:0] addr_shift;
        logic [ADDR_W-1:0]  address_offset;
    } t_cfg;

endpackage

// ----- hw/rtl/scat_cfg_regs.sv -----
module scat_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [scat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scat_pkg::ADDR_W-1:0]   i_cfg_data,
    output scat_pkg::t_cfg                o_cfg
);
    import scat_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; an index beyond the register list is dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: r_cfg.cache_enable   <= i_cfg_data[0];
                CFG_SHIFT:  r_cfg.addr_shift     <= i_cfg_data[SHIFT_W-1:0];
                CFG_OFFSET: r_cfg.address_offset <= i_cfg_data;
                default:    ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/scat_victim_lfsr.sv -----
module scat_victim_lfsr #(
    parameter int WAY_BITS = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_step,
    output logic [((WAY_BITS > 0) ? WAY_BITS : 1)-1:0] o_victim
);
    import scat_pkg::*;

    localparam int NUM_WAYS = 1 << WAY_BITS;
    localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;

    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] n_lfsr;

    // XNOR feedback from taps 7, 3, 2 and 1; the victim comes from the stepped value.
    always_comb begin
        n_lfsr   = {r_lfsr[LFSR_W-2:0], ~(r_lfsr[7] ^ r_lfsr[3] ^ r_lfsr[2] ^ r_lfsr[1])};
        o_victim = WAY_W'(n_lfsr[LFSR_W-1:1] & 7'(NUM_WAYS - 1));
    end

    // The register only advances when a miss consumes a victim.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= '0;
        end else if (i_step) begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

// ----- hw/rtl/scat_tag_pipe.sv -----
module scat_tag_pipe #(
    parameter int SET_BITS  = 6,
    parameter int WAY_BITS  = 2,
    parameter int LINE_BITS = 5
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_accept,
    input  scat_pkg::t_req                              i_req,
    input  scat_pkg::t_cfg                              i_cfg,
    input  logic [((WAY_BITS > 0) ? WAY_BITS : 1)-1:0]  i_victim,
    output logic                                        o_lfsr_step,
    output logic                                        o_busy,
    output logic                                        o_rsp_valid,
    output scat_pkg::t_rsp                              o_rsp
);
    import scat_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int NUM_WAYS = 1 << WAY_BITS;
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int TAG_W    = ADDR_W - LINE_BITS;
    localparam logic [SET_W-1:0]  SET_MASK  = SET_W'((1 << SET_BITS) - 1);
    localparam logic [SET_W-1:0]  SET_LAST  = SET_W'(NUM_SETS - 1);
    localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'((1 << LINE_BITS) - 1);

    typedef logic [NUM_WAYS-1:0]            t_vrow;
    typedef logic [NUM_WAYS-1:0][TAG_W-1:0] t_trow;

    // One row per set: the valid bits of all ways, and the tags of all ways.
    t_vrow valid_mem [NUM_SETS];
    t_trow tag_mem   [NUM_SETS];

    logic       r_s1_valid;
    t_req       r_s1_req;
    t_vrow      r_valid_rd;
    t_trow      r_tag_rd;
    logic       r_clear;
    logic [SET_W-1:0] r_clr_cnt;
    logic       r_fw_ven;
    logic       r_fw_ten;
    logic [SET_W-1:0] r_fw_set;
    t_vrow      r_fw_vrow;
    t_trow      r_fw_trow;
    logic       r_rsp_valid;
    t_rsp       r_rsp;

    logic [SET_W-1:0] rd_set;
    logic [SET_W-1:0] s1_set;
    logic [TAG_W-1:0] s1_tag;
    logic [ADDR_W-1:0] shifted;
    t_vrow      cur_vrow;
    t_trow      cur_trow;
    t_vrow      match;
    logic       hit;
    logic [WAY_W-1:0] hit_idx;
    logic       s1_ven;
    logic       s1_ten;
    t_vrow      s1_vrow;
    t_trow      s1_trow;
    t_rsp       n_rsp;
    logic       wr_ven;
    logic [SET_W-1:0] wr_set;
    t_vrow      wr_vrow;

    assign rd_set      = SET_W'(i_req.address >> LINE_BITS) & SET_MASK;
    assign o_busy      = r_clear;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Lookup stage: compare against the row read last cycle, with the row written
    // on the previous edge forwarded, since that write and this read shared an edge.
    always_comb begin
        s1_tag  = TAG_W'(r_s1_req.address >> LINE_BITS);
        s1_set  = SET_W'(r_s1_req.address >> LINE_BITS) & SET_MASK;
        shifted = r_s1_req.address << i_cfg.addr_shift;

        cur_vrow = (r_fw_ven && (r_fw_set == s1_set)) ? r_fw_vrow : r_valid_rd;
        cur_trow = (r_fw_ten && (r_fw_set == s1_set)) ? r_fw_trow : r_tag_rd;

        for (int w = 0; w < NUM_WAYS; w++) begin
            match[w] = cur_vrow[w] && (cur_trow[w] == s1_tag);
        end
        hit = |match;

        // The lowest matching way wins.
        hit_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_idx = WAY_W'(w);
            end
        end

        s1_ven      = 1'b0;
        s1_ten      = 1'b0;
        s1_vrow     = cur_vrow;
        s1_trow     = cur_trow;
        o_lfsr_step = 1'b0;
        n_rsp       = '0;
        n_rsp.outcome = OUT_INV_DONE;

        case (r_s1_req.mode)
            MODE_ACCESS: begin
                if (!i_cfg.cache_enable) begin
                    n_rsp.outcome        = OUT_BYPASS;
                    n_rsp.memory_address = shifted + i_cfg.address_offset;
                end else if (hit) begin
                    n_rsp.outcome = OUT_HIT;
                    n_rsp.hit_way = WAYOUT_W'(hit_idx);
                end else begin
                    o_lfsr_step          = r_s1_valid;
                    s1_ven               = r_s1_valid;
                    s1_ten               = r_s1_valid;
                    s1_vrow              = cur_vrow | (t_vrow'(1) << i_victim);
                    s1_trow[i_victim]    = s1_tag;
                    n_rsp.outcome        = OUT_MISS;
                    n_rsp.hit_way        = WAYOUT_W'(i_victim);
                    n_rsp.memory_address = (shifted & ~LINE_MASK) + i_cfg.address_offset;
                end
            end
            MODE_INV_LINE: begin
                s1_ven  = r_s1_valid;
                s1_vrow = cur_vrow & ~match;
            end
            default: ;
        endcase

        // The clearing pass owns the valid write port; no lookup writes meanwhile.
        wr_ven  = r_clear || s1_ven;
        wr_set  = r_clear ? r_clr_cnt : s1_set;
        wr_vrow = r_clear ? '0 : s1_vrow;
    end

    // Memories: one synchronous read and one write per cycle each.
    always_ff @(posedge i_clk) begin
        r_valid_rd <= valid_mem[rd_set];
        r_tag_rd   <= tag_mem[rd_set];
        if (wr_ven) begin
            valid_mem[wr_set] <= wr_vrow;
        end
        if (s1_ten) begin
            tag_mem[s1_set] <= s1_trow;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req <= i_req;
        end
        r_fw_set  <= wr_set;
        r_fw_vrow <= wr_vrow;
        r_fw_trow <= s1_trow;
        r_rsp     <= n_rsp;
    end

    // Control: stage valids, forwarding enables and the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_fw_ven    <= 1'b0;
            r_fw_ten    <= 1'b0;
            r_clear     <= 1'b1;
            r_clr_cnt   <= '0;
        end else begin
            r_s1_valid  <= i_accept;
            r_rsp_valid <= r_s1_valid;
            r_fw_ven    <= wr_ven;
            r_fw_ten    <= s1_ten;
            if (i_accept && (i_req.mode == MODE_INV_ALL)) begin
                r_clear   <= 1'b1;
                r_clr_cnt <= '0;
            end else if (r_clear) begin
                if (r_clr_cnt == SET_LAST) begin
                    r_clear <= 1'b0;
                end
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/set_assoc_cache_tag_lfsr.sv -----
// An accepted request is registered in the lookup stage (r_s1_valid, r_s1_req) and then in
// the response register that drives o_rsp_valid and o_rsp. Throughput: one request per cycle
// while busy is low; the tag and valid memories are read once and written once per cycle,
// and the row written last is forwarded to the following lookup. Invalidating the whole
// cache sweeps the valid memory one set per cycle: busy stays high until the last set is
// cleared. Reset (i_rst_n low, synchronous) clears the control and configuration registers
// and the LFSR and runs the same sweep. The receiver cannot stall.
module set_assoc_cache_tag_lfsr #(
    parameter int SET_BITS  = 6,
    parameter int WAY_BITS  = 2,
    parameter int LINE_BITS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  scat_pkg::t_req                 i_req,
    output logic                           o_rsp_valid,
    output scat_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scat_pkg::ADDR_W-1:0]    i_cfg_data
);
    import scat_pkg::*;

    localparam int WAY_W = (WAY_BITS > 0) ? WAY_BITS : 1;

    t_cfg             cfg;
    logic             accept;
    logic             lfsr_step;
    logic [WAY_W-1:0] victim;

    // A request is taken whenever no clearing sweep is running.
    assign accept = start && !busy;

    scat_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    scat_victim_lfsr #(
        .WAY_BITS (WAY_BITS)
    ) u_lfsr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (lfsr_step),
        .o_victim (victim)
    );

    scat_tag_pipe #(
        .SET_BITS  (SET_BITS),
        .WAY_BITS  (WAY_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_req),
        .i_cfg       (cfg),
        .i_victim    (victim),
        .o_lfsr_step (lfsr_step),
        .o_busy      (busy),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- dv/tb_set_assoc_cache_tag_lfsr.sv -----
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lfsr;
    import scat_pkg::*;

    localparam int SET_BITS  = 6;
    localparam int WAY_BITS  = 2;
    localparam int LINE_BITS = 5;
    localparam int NUM_WAYS  = 1 << WAY_BITS;
    localparam int NUM_LINES = 1 << (SET_BITS + WAY_BITS);
    localparam int TAG_W     = ADDR_W - LINE_BITS;

    // The fourth mode code has no defined meaning but must still be answered.
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

    localparam int POOL_SETS   = 3;
    localparam int TAGS_PER_SET = 6;
    localparam int POOL_SIZE   = POOL_SETS * TAGS_PER_SET;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 240;

    // Tracks tag state and replacement choices, and holds the expected results.
    class tag_scoreboard;
        logic [TAG_W-1:0]  tag_mem [NUM_LINES];
        bit                line_valid [NUM_LINES];
        logic [LFSR_W-1:0] victim_lfsr;
        bit                cache_on;
        logic [SHIFT_W-1:0] addr_shift;
        logic [ADDR_W-1:0]  addr_offset;
        t_rsp              expected_q[$];
        int                errors;

        function new();
            foreach (tag_mem[i]) begin
                tag_mem[i] = '0;
                line_valid[i] = 1'b0;
            end
            victim_lfsr = '0;
            cache_on = 1'b0;
            addr_shift = '0;
            addr_offset = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [ADDR_W-1:0] data);
            case (idx)
                CFG_ENABLE: cache_on = data[0];
                CFG_SHIFT:  addr_shift = data[SHIFT_W-1:0];
                CFG_OFFSET: addr_offset = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Steps the XNOR LFSR (taps 7,3,2,1) and returns the victim way.
        function logic [WAY_BITS-1:0] pick_victim();
            logic fb;
            fb = ~(victim_lfsr[7] ^ victim_lfsr[3] ^ victim_lfsr[2] ^ victim_lfsr[1]);
            victim_lfsr = {victim_lfsr[LFSR_W-2:0], fb};
            return victim_lfsr[WAY_BITS:1];
        endfunction

        // Applies one accepted request and queues the result it should produce.
        function void note_request(input t_req req);
            t_rsp                  rsp;
            logic [TAG_W-1:0]      tag;
            logic [SET_BITS-1:0]   set_idx;
            logic [ADDR_W-1:0]     shifted;
            logic [WAY_BITS-1:0]   way;
            int                    entry;
            bit                    hit;
            tag = req.address[ADDR_W-1:LINE_BITS];
            set_idx = tag[SET_BITS-1:0];
            shifted = req.address << addr_shift;
            rsp.outcome = OUT_INV_DONE;
            rsp.hit_way = '0;
            rsp.memory_address = '0;
            hit = 1'b0;
            case (req.mode)
                MODE_ACCESS: begin
                    if (!cache_on) begin
                        rsp.outcome = OUT_BYPASS;
                        rsp.memory_address = shifted + addr_offset;
                    end else begin
                        for (int w = 0; w < NUM_WAYS && !hit; w++) begin
                            entry = (int'(set_idx) << WAY_BITS) + w;
                            if (line_valid[entry] && tag_mem[entry] == tag) begin
                                hit = 1'b1;
                                rsp.hit_way = WAYOUT_W'(w);
                            end
                        end
                        if (hit) begin
                            rsp.outcome = OUT_HIT;
                        end else begin
                            way = pick_victim();
                            entry = (int'(set_idx) << WAY_BITS) + int'(way);
                            tag_mem[entry] = tag;
                            line_valid[entry] = 1'b1;
                            rsp.outcome = OUT_MISS;
                            rsp.hit_way = WAYOUT_W'(way);
                            rsp.memory_address =
                                {shifted[ADDR_W-1:LINE_BITS], LINE_BITS'(0)} + addr_offset;
                        end
                    end
                end
                MODE_INV_ALL: begin
                    foreach (line_valid[i]) line_valid[i] = 1'b0;
                end
                MODE_INV_LINE: begin
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        entry = (int'(set_idx) << WAY_BITS) + w;
                        if (line_valid[entry] && tag_mem[entry] == tag)
                            line_valid[entry] = 1'b0;
                    end
                end
                default: ;
            endcase
            expected_q = {expected_q, rsp};
        endfunction

        // Compares one strobed result against the oldest expectation.
        task check_result(input t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.outcome !== want.outcome)
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, want.outcome));
            if (got.hit_way !== want.hit_way)
                report_mismatch($sformatf("hit_way %0d, expected %0d",
                                          got.hit_way, want.hit_way));
            if (got.memory_address !== want.memory_address)
                report_mismatch($sformatf("memory_address %h, expected %h",
                                          got.memory_address, want.memory_address));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 i_req = '0;
    logic                 o_rsp_valid;
    t_rsp                 o_rsp;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0]    i_cfg_data = '0;

    tag_scoreboard sb = new();
    logic [ADDR_W-1:0] line_pool [POOL_SIZE];

    set_assoc_cache_tag_lfsr #(
        .SET_BITS  (SET_BITS),
        .WAY_BITS  (WAY_BITS),
        .LINE_BITS (LINE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Observe register writes, accepted requests and results at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid === 1'b1)
                sb.check_result(o_rsp);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (start && !busy)
                sb.note_request(i_req);
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
        start <= 1'b1;
        i_req <= '{mode: mode, address: addr};
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait until every expected result has come and the block is free.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
    endtask

    // One register write, after which valid is dropped and the write channel idles before return.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random gap after a request; occasionally a full drain.
    task automatic sender_gap(input int idle_pct);
        int gap;
        if ($urandom_range(199) == 0) begin
            wait_drained();
        end else if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One random request, mostly accesses to a few contended sets.
    task automatic random_request();
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        int roll;
        roll = $urandom_range(99);
        if (roll < 82)
            mode = MODE_ACCESS;
        else if (roll < 92)
            mode = MODE_INV_LINE;
        else if (roll < 94)
            mode = MODE_INV_ALL;
        else
            mode = MODE_RSVD;
        if ($urandom_range(3) != 0)
            addr = {line_pool[$urandom_range(POOL_SIZE - 1)][ADDR_W-1:LINE_BITS],
                    LINE_BITS'($urandom)};
        else
            addr = $urandom;
        send_request(mode, addr);
    endtask

    initial begin
        int idle_pct [NUM_PHASES];
        logic [SET_BITS-1:0] set_idx;
        logic [ADDR_W-1:0] line_a;
        logic [ADDR_W-1:0] offset_val;
        logic [SHIFT_W-1:0] shift_val;
        bit enable_val;
        int guard;

        idle_pct = '{0, 62, 11, 0, 62, 11, 0, 62};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bypass with reset registers, then hits, evictions and invalidation.
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_ACCESS, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(CFG_ENABLE, ($urandom & ~32'h1) | 32'h1);
        write_reg(CFG_SHIFT, ($urandom & ~32'h7) | 32'h7);
        write_reg(CFG_OFFSET, 32'hFFFF_FFFF);
        line_a = 32'h1234_5678;
        send_request(MODE_ACCESS, line_a);
        send_request(MODE_ACCESS, line_a);
        send_request(MODE_ACCESS, line_a ^ 32'h1F);
        for (int i = 1; i <= 4; i++)
            send_request(MODE_ACCESS, line_a + (i << (LINE_BITS + SET_BITS)));
        send_request(MODE_RSVD, line_a);
        send_request(MODE_INV_LINE, line_a);
        send_request(MODE_ACCESS, line_a);
        send_request(MODE_INV_LINE, 32'hDEAD_BEE0);
        send_request(MODE_INV_ALL, 32'h0000_0000);
        send_request(MODE_ACCESS, line_a);
        send_request(MODE_ACCESS, 32'hFFFF_FFFF);
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_ACCESS, 32'h0000_0000);
        send_request(MODE_INV_LINE, 32'hFFFF_FFFF);
        send_request(MODE_RSVD, 32'hFFFF_FFFF);
        wait_drained();

        // Random phases, each under its own register setting and idle rate.
        for (int p = 0; p < NUM_PHASES; p++) begin
            enable_val = (p != 2 && p != 5);
            case (p)
                0: begin shift_val = '0; offset_val = '0; end
                1: begin shift_val = '1; offset_val = 32'hFFFF_FFFF; end
                default: begin shift_val = SHIFT_W'($urandom); offset_val = $urandom; end
            endcase
            write_reg(CFG_ENABLE, ($urandom & ~32'h1) | enable_val);
            write_reg(CFG_SHIFT, ($urandom & ~32'h7) | shift_val);
            write_reg(CFG_OFFSET, offset_val);

            for (int s = 0; s < POOL_SETS; s++) begin
                set_idx = SET_BITS'($urandom);
                for (int t = 0; t < TAGS_PER_SET; t++)
                    line_pool[s * TAGS_PER_SET + t] =
                        {(ADDR_W - SET_BITS - LINE_BITS)'($urandom), set_idx, LINE_BITS'(0)};
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request();
                sender_gap(idle_pct[p]);
            end
            wait_drained();
        end

        // Let any late or spurious result show up, then judge the run.
        guard = 0;
        while ((sb.pending() != 0 || busy) && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
